### hw/rtl/dema_pkg.sv
// shared types and constants for the dual exponential-average trend classifier
// no dependencies; imported by every module of the block
package dema_pkg;

    localparam int ALPHA_W   = 17;
    localparam int SAMPLE_W  = 24;
    localparam int ACC_W     = 32;
    localparam int CNT_W     = 32;
    // multiplicand width covers (step - velocity), quotient width covers nv before saturation
    localparam int MCAND_W   = 34;
    localparam int QUOT_W    = 36;
    localparam int MUL_STEPS = ALPHA_W;
    localparam int FRAC_SH   = 16;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'h10000;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd6554;
    localparam logic [CNT_W-1:0]   CNT_MAX     = '1;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    localparam logic REG_LEVEL_ALPHA = 1'b0;
    localparam logic REG_SLOPE_ALPHA = 1'b1;

    typedef enum logic [1:0] {
        Q_RISING     = 2'd0,
        Q_FADING     = 2'd1,
        Q_FALLING    = 2'd2,
        Q_RECOVERING = 2'd3
    } t_quadrant;

    typedef struct packed {
        logic                       cmd;
        logic signed [SAMPLE_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic signed [ACC_W-1:0] level_avg;
        logic signed [ACC_W-1:0] velocity_avg;
        t_quadrant               quadrant;
        t_quadrant               prior_quadrant;
        logic                    changed;
        logic [CNT_W-1:0]        transition_count;
        logic [CNT_W-1:0]        sample_count;
    } t_out_item;

    typedef struct packed {
        logic [ALPHA_W-1:0] level_alpha;
        logic [ALPHA_W-1:0] slope_alpha;
    } t_cfg;

    typedef struct packed {
        logic                      start;
        logic signed [MCAND_W-1:0] mcand;
        logic [ALPHA_W-1:0]        mplier;
    } t_mul_req;

    typedef struct packed {
        logic                     done;
        logic signed [QUOT_W-1:0] quot;
    } t_mul_rsp;

    // values above one act as one
    function automatic logic [ALPHA_W-1:0] clamp_alpha(input logic [ALPHA_W-1:0] a);
        return a[ALPHA_W-1] ? ALPHA_ONE : a;
    endfunction

    function automatic t_quadrant classify(input logic level_neg, input logic vel_neg);
        t_quadrant q;
        case ({level_neg, vel_neg})
            2'b00:   q = Q_RISING;
            2'b01:   q = Q_FADING;
            2'b11:   q = Q_FALLING;
            2'b10:   q = Q_RECOVERING;
            default: q = Q_RISING;
        endcase
        return q;
    endfunction

endpackage

### hw/rtl/dema_cfg.sv
// configuration registers behind the apb-style port
// depends on dema_pkg
module dema_cfg import dema_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [ALPHA_W-1:0] r_level_alpha;
    logic [ALPHA_W-1:0] r_slope_alpha;
    logic               w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_alpha <= ALPHA_RESET;
            r_slope_alpha <= ALPHA_RESET;
        end else if (w_wr) begin
            case (paddr[2])
                REG_LEVEL_ALPHA: r_level_alpha <= pwdata[ALPHA_W-1:0];
                REG_SLOPE_ALPHA: r_slope_alpha <= pwdata[ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_LEVEL_ALPHA: prdata = {{(32-ALPHA_W){1'b0}}, r_level_alpha};
            REG_SLOPE_ALPHA: prdata = {{(32-ALPHA_W){1'b0}}, r_slope_alpha};
            default:         prdata = '0;
        endcase
    end

    assign o_cfg.level_alpha = clamp_alpha(r_level_alpha);
    assign o_cfg.slope_alpha = clamp_alpha(r_slope_alpha);

endmodule

### hw/rtl/dema_mul.sv
// bit-serial shift-and-add multiplier, one smoothing-factor bit per cycle
// gives floor(alpha * mcand / 65536); depends on dema_pkg
module dema_mul import dema_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    localparam int CNT_BITS = $clog2(MUL_STEPS);

    logic                      r_busy;
    logic                      r_done;
    logic [CNT_BITS-1:0]       r_cnt;
    logic signed [MCAND_W-1:0] r_mcand;
    logic [ALPHA_W-1:0]        r_mplier;
    logic signed [QUOT_W-1:0]  r_hi;
    logic [ALPHA_W-1:0]        r_lo;
    logic signed [QUOT_W-1:0]  n_sum;

    // partial sum stays narrow: the product leaves through r_lo one bit a cycle
    assign n_sum = r_hi + (r_mplier[0] ? QUOT_W'(r_mcand) : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy   <= 1'b1;
                r_cnt    <= '0;
                r_hi     <= '0;
                r_lo     <= '0;
                r_mcand  <= i_req.mcand;
                r_mplier <= i_req.mplier;
            end else if (r_busy) begin
                r_hi     <= n_sum >>> 1;
                r_lo     <= {n_sum[0], r_lo[ALPHA_W-1:1]};
                r_mplier <= r_mplier >> 1;
                r_cnt    <= r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // full product is {r_hi, r_lo}; the arithmetic shift by 16 keeps r_lo's top bit
    assign o_rsp.done = r_done;
    assign o_rsp.quot = {r_hi[QUOT_W-2:0], r_lo[ALPHA_W-1]};

endmodule

### hw/rtl/dual_ema_trend_quadrant.sv
// An accepted sample runs two passes of the bit-serial multiplier (level, then
// velocity), each of 17 shift-and-add steps and then the done flag, then the classify
// state and the load of the output register. A clear command goes straight to the
// output state, and the first sample after a clear skips the multiplier. One sample
// is in flight at a time and the next is taken the cycle after the result is loaded;
// it is taken while the previous result still waits in the output register.
// depends on dema_pkg, dema_cfg, dema_mul
module dual_ema_trend_quadrant import dema_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LMUL,
        S_VMUL,
        S_CLASS,
        S_OUT
    } t_state;

    t_state                   r_state;
    logic signed [ACC_W-1:0]  r_level;
    logic signed [ACC_W-1:0]  r_vel;
    logic                     r_seeded;
    t_quadrant                r_quad;
    t_quadrant                r_prior;
    logic                     r_changed;
    logic [CNT_W-1:0]         r_samples;
    logic [CNT_W-1:0]         r_trans;
    logic                     r_out_valid;
    t_out_item                r_out_data;

    t_cfg                     w_cfg;
    t_mul_req                 w_req;
    t_mul_rsp                 w_rsp;
    logic                     w_accept;
    logic signed [ACC_W-1:0]  w_target;
    logic signed [QUOT_W-1:0] n_vel_wide;
    t_quadrant                n_quad;

    dema_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    dema_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_target   = {i_in_data.sample, 8'b0};
    assign n_vel_wide = QUOT_W'(r_vel) + w_rsp.quot;
    assign n_quad     = classify(r_level[ACC_W-1], r_vel[ACC_W-1]);

    // level pass starts on acceptance, velocity pass as soon as the level step is known
    always_comb begin
        w_req = '0;
        if (w_accept && i_in_data.cmd == CMD_RECORD && r_seeded) begin
            w_req.start  = 1'b1;
            w_req.mcand  = MCAND_W'(w_target) - MCAND_W'(r_level);
            w_req.mplier = w_cfg.level_alpha;
        end else if (r_state == S_LMUL && w_rsp.done) begin
            w_req.start  = 1'b1;
            w_req.mcand  = w_rsp.quot[MCAND_W-1:0] - MCAND_W'(r_vel);
            w_req.mplier = w_cfg.slope_alpha;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_level     <= '0;
            r_vel       <= '0;
            r_seeded    <= 1'b0;
            r_quad      <= Q_RISING;
            r_prior     <= Q_RISING;
            r_changed   <= 1'b0;
            r_samples   <= '0;
            r_trans     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // the output state reloads the register itself
            if (!i_out_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_changed <= 1'b0;
                        if (i_in_data.cmd == CMD_CLEAR) begin
                            r_level   <= '0;
                            r_vel     <= '0;
                            r_seeded  <= 1'b0;
                            r_quad    <= Q_RISING;
                            r_prior   <= Q_RISING;
                            r_samples <= '0;
                            r_trans   <= '0;
                            r_state   <= S_OUT;
                        end else begin
                            r_prior <= r_quad;
                            if (r_seeded) begin
                                r_state <= S_LMUL;
                            end else begin
                                r_level  <= w_target;
                                r_vel    <= '0;
                                r_seeded <= 1'b1;
                                r_state  <= S_CLASS;
                            end
                        end
                    end
                end
                S_LMUL: begin
                    if (w_rsp.done) begin
                        // level moves toward the target so it never leaves its range
                        r_level <= r_level + w_rsp.quot[ACC_W-1:0];
                        r_state <= S_VMUL;
                    end
                end
                S_VMUL: begin
                    if (w_rsp.done) begin
                        if (n_vel_wide[QUOT_W-1:ACC_W-1] == '0 ||
                            n_vel_wide[QUOT_W-1:ACC_W-1] == '1) begin
                            r_vel <= n_vel_wide[ACC_W-1:0];
                        end else if (n_vel_wide[QUOT_W-1]) begin
                            r_vel <= {1'b1, {(ACC_W-1){1'b0}}};
                        end else begin
                            r_vel <= {1'b0, {(ACC_W-1){1'b1}}};
                        end
                        r_state <= S_CLASS;
                    end
                end
                S_CLASS: begin
                    if (n_quad != r_quad) begin
                        // first placement after a clear is not a transition
                        if (r_samples != '0) begin
                            r_changed <= 1'b1;
                            if (r_trans != CNT_MAX) begin
                                r_trans <= r_trans + 1'b1;
                            end
                        end
                        r_quad <= n_quad;
                    end
                    if (r_samples != CNT_MAX) begin
                        r_samples <= r_samples + 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid                 <= 1'b1;
                        r_out_data.level_avg        <= r_level;
                        r_out_data.velocity_avg     <= r_vel;
                        r_out_data.quadrant         <= r_quad;
                        r_out_data.prior_quadrant   <= r_prior;
                        r_out_data.changed          <= r_changed;
                        r_out_data.transition_count <= r_trans;
                        r_out_data.sample_count     <= r_samples;
                        r_state                     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_mul_done_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_LMUL || r_state == S_VMUL))
        else $error("multiplier finished outside a multiply pass");

    a_trans_le_samples: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data.transition_count <= r_out_data.sample_count))
        else $error("more transitions than samples");

    a_changed_quadrant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.changed) |->
            (r_out_data.quadrant != r_out_data.prior_quadrant))
        else $error("change flagged without a quadrant change");

    a_unseeded_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_seeded |-> (r_samples == '0 && r_trans == '0))
        else $error("counts held while unseeded");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && (!r_out_valid || !i_out_stall)) |=> (r_out_valid && !o_in_stall))
        else $error("result not presented on leaving the output state");

endmodule
